// ----- hw/rtl/tte_pkg.sv -----
// Package for the timer table expiry block: operation and status codes,
// the slot record type and the sequencer state type. No dependencies.
package tte_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    typedef enum logic [1:0] {
        OP_SET        = 2'd0,
        OP_CANCEL     = 2'd1,
        OP_CANCEL_CLT = 2'd2,
        OP_POLL       = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_SET_OK      = 3'd0,
        ST_TABLE_FULL  = 3'd1,
        ST_CANCELLED   = 3'd2,
        ST_NOT_FOUND   = 3'd3,
        ST_CLT_CANCEL  = 3'd4,
        ST_OUT_EXPIRED = 3'd5,
        ST_CLT_EXPIRED = 3'd6,
        ST_NONE_DUE    = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DECIDE,
        S_EMIT
    } t_state;

    // One table entry as stored in the slot memory.
    typedef struct packed {
        logic [31:0] id;
        logic [63:0] nonce;
        logic [32:0] expiry;
        logic [31:0] order;
    } t_slot;

endpackage

// ----- hw/rtl/tte_slot_ram.sv -----
// Slot memory of the timer table: one write port, one read port with
// registered read data. Depends on tte_pkg for the slot record type.
module tte_slot_ram
    import tte_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
    localparam int AW = $clog2(TIMER_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_slot         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_slot         o_rdata
);

    t_slot r_mem [TIMER_SLOTS];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/timer_table_expiry_top.sv -----
// Timer table expiry block: a sequencer that sweeps the slot table one entry
// at a time with a single compare unit. Depends on tte_pkg and tte_slot_ram.
//
// Each sweep of the table reads every entry from the memory, then compares
// it; after the sweep the result is decided and loaded into the output
// register once it is free. Cancel and cancel-by-nonce take one sweep.
// Set takes one sweep per id candidate tried (one more per live id the id
// counter collides with); poll takes one sweep per expired timer plus one.
// One operation is worked at a time; the next beat is taken once the last
// result is in the output register. Reset (synchronous, active low) empties
// the table and clears the id and insertion counters.
module timer_table_expiry_top
    import tte_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input beat, from bit 0: op[2], now_time[32], elapse[20], nonce[64],
    // timer_id[32], two zero pad bits.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [151:0] i_s_tdata,
    // Result beat, from bit 0: status[3], result_id[32], result_nonce[64],
    // removed_count[5].
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,
    output logic         o_m_tlast
);

    localparam int AW = $clog2(TIMER_SLOTS);
    localparam logic [AW-1:0] LAST_IDX = AW'(TIMER_SLOTS - 1);

    // Control state.
    t_state           r_state, n_state;
    logic [TIMER_SLOTS-1:0] r_valid, n_valid;
    logic [31:0]      r_id_ctr, n_id_ctr;
    logic [31:0]      r_ord_ctr, n_ord_ctr;
    logic             r_m_valid, n_m_valid;
    logic             r_pend_valid, n_pend_valid;

    // Operation context and sweep accumulators.
    t_op              r_op, n_op;
    logic [31:0]      r_now, n_now;
    logic [19:0]      r_elapse, n_elapse;
    logic [63:0]      r_nonce, n_nonce;
    logic [31:0]      r_tid, n_tid;
    logic [AW-1:0]    r_idx, n_idx;
    logic [31:0]      r_cand, n_cand;
    logic             r_hit, n_hit;
    logic [AW-1:0]    r_hit_idx, n_hit_idx;
    logic             r_free_found, n_free_found;
    logic [AW-1:0]    r_free_idx, n_free_idx;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_best_found, n_best_found;
    logic [AW-1:0]    r_best_idx, n_best_idx;
    logic [32:0]      r_best_exp, n_best_exp;
    logic [31:0]      r_best_age, n_best_age;
    logic [31:0]      r_best_id, n_best_id;
    logic [63:0]      r_best_nonce, n_best_nonce;

    // Held poll result, sent once it is known whether another one follows.
    t_status          r_pend_status, n_pend_status;
    logic [31:0]      r_pend_id, n_pend_id;
    logic [63:0]      r_pend_nonce, n_pend_nonce;

    // Staged result and the output register.
    t_status          r_res_status, n_res_status;
    logic [31:0]      r_res_id, n_res_id;
    logic [63:0]      r_res_nonce, n_res_nonce;
    logic [4:0]       r_res_cnt, n_res_cnt;
    logic             r_res_last, n_res_last;
    logic             r_more, n_more;
    logic [103:0]     r_m_data, n_m_data;
    logic             r_m_last, n_m_last;

    // Memory port.
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    t_slot            ram_wdata;
    t_slot            ram_rdata;

    logic             s_accept;
    logic [31:0]      ent_age;
    logic [32:0]      poll_limit;
    logic [31:0]      cand_next;
    logic             poll_better;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

    tte_slot_ram #(
        .TIMER_SLOTS(TIMER_SLOTS)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    // The shared compare unit: the entry under the sweep against the
    // operation's key, and for poll against the best candidate so far.
    // A larger age means the timer was inserted earlier.
    assign ent_age     = r_ord_ctr - ram_rdata.order;
    assign poll_limit  = {1'b0, r_now} + 33'd1;
    assign cand_next   = (r_cand == 32'hFFFF_FFFF) ? 32'd1 : r_cand + 32'd1;
    assign poll_better = !r_best_found || (ram_rdata.expiry < r_best_exp) ||
                         ((ram_rdata.expiry == r_best_exp) && (ent_age > r_best_age));

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_id_ctr      = r_id_ctr;
        n_ord_ctr     = r_ord_ctr;
        n_m_valid     = r_m_valid;
        n_pend_valid  = r_pend_valid;
        n_op          = r_op;
        n_now         = r_now;
        n_elapse      = r_elapse;
        n_nonce       = r_nonce;
        n_tid         = r_tid;
        n_idx         = r_idx;
        n_cand        = r_cand;
        n_hit         = r_hit;
        n_hit_idx     = r_hit_idx;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_cnt         = r_cnt;
        n_best_found  = r_best_found;
        n_best_idx    = r_best_idx;
        n_best_exp    = r_best_exp;
        n_best_age    = r_best_age;
        n_best_id     = r_best_id;
        n_best_nonce  = r_best_nonce;
        n_pend_status = r_pend_status;
        n_pend_id     = r_pend_id;
        n_pend_nonce  = r_pend_nonce;
        n_res_status  = r_res_status;
        n_res_id      = r_res_id;
        n_res_nonce   = r_res_nonce;
        n_res_cnt     = r_res_cnt;
        n_res_last    = r_res_last;
        n_more        = r_more;
        n_m_data      = r_m_data;
        n_m_last      = r_m_last;
        ram_we        = 1'b0;
        ram_waddr     = r_free_idx;
        ram_wdata.id     = r_cand;
        ram_wdata.nonce  = r_nonce;
        ram_wdata.expiry = {1'b0, r_now} + {13'd0, r_elapse};
        ram_wdata.order  = r_ord_ctr;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_op         = t_op'(i_s_tdata[1:0]);
                    n_now        = i_s_tdata[33:2];
                    n_elapse     = i_s_tdata[53:34];
                    n_nonce      = i_s_tdata[117:54];
                    n_tid        = i_s_tdata[149:118];
                    n_idx        = '0;
                    n_cand       = (r_id_ctr == 32'd0) ? 32'd1 : r_id_ctr;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_cnt        = '0;
                    n_best_found = 1'b0;
                    n_pend_valid = 1'b0;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                case (r_op)
                    OP_SET: begin
                        if (!r_valid[r_idx] && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_idx;
                        end
                        if (r_valid[r_idx] && (ram_rdata.id == r_cand)) begin
                            n_hit = 1'b1;
                        end
                    end
                    OP_CANCEL: begin
                        if (r_valid[r_idx] && (r_tid != 32'd0) &&
                            (ram_rdata.id == r_tid) && !r_hit) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_idx;
                        end
                    end
                    OP_CANCEL_CLT: begin
                        if (r_valid[r_idx] && (ram_rdata.nonce == r_nonce)) begin
                            n_valid[r_idx] = 1'b0;
                            n_cnt          = r_cnt + 5'd1;
                        end
                    end
                    default: begin
                        if (r_valid[r_idx] && (ram_rdata.expiry <= poll_limit) &&
                            poll_better) begin
                            n_best_found = 1'b1;
                            n_best_idx   = r_idx;
                            n_best_exp   = ram_rdata.expiry;
                            n_best_age   = ent_age;
                            n_best_id    = ram_rdata.id;
                            n_best_nonce = ram_rdata.nonce;
                        end
                    end
                endcase
                if (r_idx == LAST_IDX) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_READ;
                end
            end
            S_DECIDE: begin
                n_res_status = ST_NONE_DUE;
                n_res_id     = '0;
                n_res_nonce  = '0;
                n_res_cnt    = '0;
                n_res_last   = 1'b1;
                n_more       = 1'b0;
                n_state      = S_EMIT;
                case (r_op)
                    OP_SET: begin
                        if (!r_free_found) begin
                            n_res_status = ST_TABLE_FULL;
                        end else if (r_hit) begin
                            // Candidate id is live: try the next one.
                            n_cand  = cand_next;
                            n_hit   = 1'b0;
                            n_idx   = '0;
                            n_state = S_READ;
                        end else begin
                            ram_we              = 1'b1;
                            n_valid[r_free_idx] = 1'b1;
                            n_id_ctr            = r_cand;
                            n_ord_ctr           = r_ord_ctr + 32'd1;
                            n_res_status        = ST_SET_OK;
                            n_res_id            = r_cand;
                        end
                    end
                    OP_CANCEL: begin
                        if (r_hit) begin
                            n_valid[r_hit_idx] = 1'b0;
                            n_res_status       = ST_CANCELLED;
                            n_res_id           = r_tid;
                        end else begin
                            n_res_status = ST_NOT_FOUND;
                        end
                    end
                    OP_CANCEL_CLT: begin
                        n_res_status = ST_CLT_CANCEL;
                        n_res_cnt    = r_cnt;
                    end
                    default: begin
                        if (r_best_found) begin
                            n_valid[r_best_idx] = 1'b0;
                            n_pend_valid  = 1'b1;
                            n_pend_status = (r_best_nonce == 64'd0) ? ST_OUT_EXPIRED
                                                                    : ST_CLT_EXPIRED;
                            n_pend_id     = r_best_id;
                            n_pend_nonce  = r_best_nonce;
                            if (r_pend_valid) begin
                                // Another timer is due, so the held one is not last.
                                n_res_status = r_pend_status;
                                n_res_id     = r_pend_id;
                                n_res_nonce  = r_pend_nonce;
                                n_res_last   = 1'b0;
                                n_more       = 1'b1;
                            end else begin
                                n_idx        = '0;
                                n_best_found = 1'b0;
                                n_state      = S_READ;
                            end
                        end else begin
                            n_pend_valid = 1'b0;
                            if (r_pend_valid) begin
                                n_res_status = r_pend_status;
                                n_res_id     = r_pend_id;
                                n_res_nonce  = r_pend_nonce;
                            end
                        end
                    end
                endcase
            end
            S_EMIT: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {r_res_cnt, r_res_nonce, r_res_id, r_res_status};
                    n_m_last  = r_res_last;
                    if (r_more) begin
                        n_idx        = '0;
                        n_best_found = 1'b0;
                        n_state      = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_id_ctr     <= '0;
            r_ord_ctr    <= '0;
            r_m_valid    <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_id_ctr     <= n_id_ctr;
            r_ord_ctr    <= n_ord_ctr;
            r_m_valid    <= n_m_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_now         <= n_now;
        r_elapse      <= n_elapse;
        r_nonce       <= n_nonce;
        r_tid         <= n_tid;
        r_idx         <= n_idx;
        r_cand        <= n_cand;
        r_hit         <= n_hit;
        r_hit_idx     <= n_hit_idx;
        r_free_found  <= n_free_found;
        r_free_idx    <= n_free_idx;
        r_cnt         <= n_cnt;
        r_best_found  <= n_best_found;
        r_best_idx    <= n_best_idx;
        r_best_exp    <= n_best_exp;
        r_best_age    <= n_best_age;
        r_best_id     <= n_best_id;
        r_best_nonce  <= n_best_nonce;
        r_pend_status <= n_pend_status;
        r_pend_id     <= n_pend_id;
        r_pend_nonce  <= n_pend_nonce;
        r_res_status  <= n_res_status;
        r_res_id      <= n_res_id;
        r_res_nonce   <= n_res_nonce;
        r_res_cnt     <= n_res_cnt;
        r_res_last    <= n_res_last;
        r_more        <= n_more;
        r_m_data      <= n_m_data;
        r_m_last      <= n_m_last;
    end

    // A new timer is only ever written into a slot that is free.
    a_write_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !r_valid[ram_waddr])
        else $error("timer written over a live slot");

    // Once a beat is taken the block is busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("input taken while an operation is in flight");

    // A held poll result exists only while a poll is in flight.
    a_pend_poll_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_op == OP_POLL) && (r_state != S_IDLE))
        else $error("held poll result outside a poll");

    // The id candidate of a set never becomes zero.
    a_cand_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_IDLE) && (r_op == OP_SET)) |-> (r_cand != 32'd0))
        else $error("zero id candidate");

    // A set leaves the id counter on the id it handed out.
    a_id_ctr_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_id_ctr == $past(r_cand)))
        else $error("id counter not on allocated id");

endmodule

// ----- sim/tb_timer_table_expiry_top.sv -----
// Self-checking testbench for the timer table expiry block: a directed table
// of operations, then random traffic, checked against a behavioral predictor.
// Depends on tte_pkg and timer_table_expiry_top.
module tb_timer_table_expiry_top;
    import tte_pkg::*;

    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    // One request beat in field form.
    typedef struct {
        t_op         op;
        logic [31:0] now_time;
        logic [19:0] elapse;
        logic [63:0] nonce;
        logic [31:0] timer_id;
    } t_req;

    // One result beat in field form.
    typedef struct {
        t_status     status;
        logic [31:0] id;
        logic [63:0] nonce;
        logic [4:0]  count;
        logic        last;
    } t_rsp;

    // A directed row: request plus an optional typed-in expectation.
    typedef struct {
        t_req req;
        bit   has_exp;
        t_rsp exp;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [151:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [103:0] o_m_tdata;
    logic         o_m_tlast;

    always #5 i_clk = ~i_clk;

    timer_table_expiry_top #(.TIMER_SLOTS(SLOTS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Shadow copy of the timer table.
    bit          tbl_live[SLOTS];
    logic [31:0] tbl_id[SLOTS];
    logic [63:0] tbl_nonce[SLOTS];
    logic [32:0] tbl_expiry[SLOTS];
    logic [31:0] tbl_seq[SLOTS];
    logic [31:0] next_id;
    logic [31:0] next_seq;

    t_rsp pending_rsp[$];
    int   mismatches = 0;
    int   rsp_seen = 0;
    int   idle_cycles = 0;
    bit   hold_rx = 1'b0;
    bit   no_idle = 1'b0;

    function automatic bit id_live(logic [31:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_live[i] && tbl_id[i] == id) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) n += tbl_live[i];
        return n;
    endfunction

    function automatic t_rsp mk_rsp(t_status st, logic [31:0] id, logic [63:0] nonce,
                                    logic [4:0] cnt);
        t_rsp r;
        r.status = st;
        r.id = id;
        r.nonce = nonce;
        r.count = cnt;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic bit same_rsp(t_rsp a, t_rsp b);
        return a.status === b.status && a.id === b.id && a.nonce === b.nonce &&
               a.count === b.count && a.last === b.last;
    endfunction

    // Apply one request to the shadow table and queue the results it causes.
    task automatic predict_timer_op(t_req rq);
        t_rsp  batch[$];
        int    slot;
        int    cnt;
        int    best;
        logic [32:0] limit;
        slot = -1;
        case (rq.op)
            OP_SET: begin
                for (int i = 0; i < SLOTS; i++)
                    if (!tbl_live[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    batch = {batch, mk_rsp(ST_TABLE_FULL, '0, '0, '0)};
                end else begin
                    while (next_id == 0 || id_live(next_id)) next_id++;
                    tbl_live[slot] = 1'b1;
                    tbl_id[slot] = next_id;
                    tbl_nonce[slot] = rq.nonce;
                    tbl_expiry[slot] = {1'b0, rq.now_time} + {13'b0, rq.elapse};
                    tbl_seq[slot] = next_seq;
                    next_seq++;
                    batch = {batch, mk_rsp(ST_SET_OK, next_id, '0, '0)};
                end
            end
            OP_CANCEL: begin
                if (rq.timer_id != 0)
                    for (int i = 0; i < SLOTS; i++)
                        if (slot < 0 && tbl_live[i] && tbl_id[i] == rq.timer_id) slot = i;
                if (slot < 0) begin
                    batch = {batch, mk_rsp(ST_NOT_FOUND, '0, '0, '0)};
                end else begin
                    tbl_live[slot] = 1'b0;
                    batch = {batch, mk_rsp(ST_CANCELLED, rq.timer_id, '0, '0)};
                end
            end
            OP_CANCEL_CLT: begin
                cnt = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_live[i] && tbl_nonce[i] == rq.nonce) begin
                        tbl_live[i] = 1'b0;
                        cnt++;
                    end
                batch = {batch, mk_rsp(ST_CLT_CANCEL, '0, '0, cnt[4:0])};
            end
            default: begin
                limit = {1'b0, rq.now_time} + 33'd1;
                forever begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!tbl_live[i] || tbl_expiry[i] > limit) continue;
                        // Equal expiry: the older insertion, by wrapped age, goes first.
                        if (best < 0 || tbl_expiry[i] < tbl_expiry[best] ||
                            (tbl_expiry[i] == tbl_expiry[best] &&
                             32'(next_seq - tbl_seq[i]) > 32'(next_seq - tbl_seq[best])))
                            best = i;
                    end
                    if (best < 0) break;
                    tbl_live[best] = 1'b0;
                    batch = {batch, mk_rsp(tbl_nonce[best] == 0 ? ST_OUT_EXPIRED
                                                                : ST_CLT_EXPIRED,
                                           tbl_id[best], tbl_nonce[best], '0)};
                end
                if (batch.size() == 0) batch = {batch, mk_rsp(ST_NONE_DUE, '0, '0, '0)};
            end
        endcase
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[k]) pending_rsp = {pending_rsp, batch[k]};
    endtask

    // Drive one beat at the falling edge and hold it until it is taken.
    task automatic send_op(t_req rq);
        while (!no_idle && $urandom_range(99) < 10) @(negedge i_clk);
        i_s_tdata = {2'b0, rq.timer_id, rq.nonce, rq.elapse, rq.now_time, rq.op};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        predict_timer_op(rq);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    // Receiver: random stalls unless held off or in a no-idle stretch.
    always @(negedge i_clk)
        i_m_tready <= !hold_rx && (no_idle || $urandom_range(99) >= 10);

    // Result checker at the rising edge.
    always @(posedge i_clk) begin
        t_rsp got, exp;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status = t_status'(o_m_tdata[2:0]);
            got.id = o_m_tdata[34:3];
            got.nonce = o_m_tdata[98:35];
            got.count = o_m_tdata[103:99];
            got.last = o_m_tlast;
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %0p", got);
            end else begin
                exp = pending_rsp.pop_front();
                if (got.status !== exp.status || got.id !== exp.id ||
                    got.nonce !== exp.nonce || got.count !== exp.count ||
                    got.last !== exp.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: expected %0p, got %0p",
                                 rsp_seen, exp, got);
                end
            end
        end
    end

    // Watchdog on cycles with no beat accepted on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_req mk_req(t_op op, logic [31:0] now_time, logic [19:0] elapse,
                                    logic [63:0] nonce, logic [31:0] tid);
        t_req r;
        r.op = op;
        r.now_time = now_time;
        r.elapse = elapse;
        r.nonce = nonce;
        r.timer_id = tid;
        return r;
    endfunction

    function automatic t_row row(t_req rq);
        t_row r;
        r.req = rq;
        r.has_exp = 1'b0;
        return r;
    endfunction

    function automatic t_row row_exp(t_req rq, t_rsp ex);
        t_row r;
        r.req = rq;
        r.has_exp = 1'b1;
        r.exp = ex;
        r.exp.last = 1'b1;
        return r;
    endfunction

    // Pick a nonce, mostly from a small pool, so cancel-by-nonce finds matches.
    function automatic logic [63:0] pick_nonce();
        case ($urandom_range(4))
            0: return '0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return {$urandom, $urandom};
            default: return 64'(1 + $urandom_range(3));
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_rsp.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_row        rows[$];
        t_req        rq;
        logic [31:0] clock_now;
        int          pick;
        int          lo;
        logic [31:0] live_ids[$];

        // Directed table. After reset the id counter starts at zero, so the
        // first set returns id 1 and the next id 2.
        rows = {rows, row_exp(mk_req(OP_POLL, 32'd0, '0, '0, '0),
                              mk_rsp(ST_NONE_DUE, '0, '0, '0))};
        rows = {rows, row_exp(mk_req(OP_CANCEL, '0, '0, '0, 32'd0),
                              mk_rsp(ST_NOT_FOUND, '0, '0, '0))};
        rows = {rows, row_exp(mk_req(OP_CANCEL, '0, '0, '0, 32'hFFFF_FFFF),
                              mk_rsp(ST_NOT_FOUND, '0, '0, '0))};
        rows = {rows, row_exp(mk_req(OP_CANCEL_CLT, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0),
                              mk_rsp(ST_CLT_CANCEL, '0, '0, '0))};
        rows = {rows, row_exp(mk_req(OP_SET, 32'd100, 20'd0, 64'd0, '0),
                              mk_rsp(ST_SET_OK, 32'd1, '0, '0))};
        rows = {rows, row_exp(mk_req(OP_SET, 32'hFFFF_FFFF, 20'hFFFFF,
                                     64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF),
                              mk_rsp(ST_SET_OK, 32'd2, '0, '0))};
        // Ties in expiry: equal-expiry timers must come out in insertion order.
        rows = {rows, row(mk_req(OP_SET, 32'd90, 20'd10, 64'd5, '0))};
        rows = {rows, row(mk_req(OP_SET, 32'd95, 20'd5, 64'd0, '0))};
        rows = {rows, row(mk_req(OP_SET, 32'd50, 20'd51, 64'd7, '0))};
        rows = {rows, row(mk_req(OP_POLL, 32'd99, '0, '0, '0))};
        rows = {rows, row_exp(mk_req(OP_CANCEL, '0, '0, '0, 32'd2),
                              mk_rsp(ST_CANCELLED, 32'd2, '0, '0))};
        // Fill the table with one owner, overflow it, then clear by owner.
        // One timer of another owner is still live, so that owner holds all
        // but one slot.
        for (int i = 0; i < SLOTS; i++)
            rows = {rows, row(mk_req(OP_SET, 32'd1000, 20'(i), 64'hAAAA_5555_0000_0001,
                                     '0))};
        rows = {rows, row_exp(mk_req(OP_SET, 32'd1000, 20'd1, 64'd1, '0),
                              mk_rsp(ST_TABLE_FULL, '0, '0, '0))};
        rows = {rows, row_exp(mk_req(OP_CANCEL_CLT, '0, '0, 64'hAAAA_5555_0000_0001, '0),
                              mk_rsp(ST_CLT_CANCEL, '0, '0, 5'(SLOTS - 1)))};

        tbl_live = '{default: 1'b0};
        next_id = '0;
        next_seq = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            if (rows[r].has_exp) begin
                wait_drained();
                send_op(rows[r].req);
                if (pending_rsp.size() != 1 || !same_rsp(pending_rsp[0], rows[r].exp)) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("directed row %0d: predictor disagrees with table", r);
                end
            end else begin
                send_op(rows[r].req);
            end
        end

        // Sender keeps offering while the receiver holds off, so the block
        // backs up and stalls its input.
        fork
            begin
                hold_rx = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            for (int i = 0; i < 6; i++)
                send_op(mk_req(t_op'($urandom_range(3)), 32'd2000, 20'd3, pick_nonce(),
                               32'($urandom_range(20))));
        join
        wait_drained();

        // Random part: a slowly advancing clock, mostly sets and polls.
        clock_now = $urandom;
        for (int n = 0; n < 240; n++) begin
            no_idle = (n >= 100 && n < 140);
            if (n == 180) wait_drained();
            clock_now += $urandom_range(3);
            pick = $urandom_range(99);
            lo = live_count();
            if (pick < 45 - 2 * lo)
                rq = mk_req(OP_SET, clock_now, 20'($urandom_range(4)), pick_nonce(), $urandom);
            else if (pick < 50)
                rq = mk_req(OP_SET, $urandom, 20'($urandom), pick_nonce(), $urandom);
            else if (pick < 65) begin
                live_ids.delete();
                for (int i = 0; i < SLOTS; i++) if (tbl_live[i]) live_ids = {live_ids, tbl_id[i]};
                rq = mk_req(OP_CANCEL, $urandom, 20'($urandom), {$urandom, $urandom},
                            (live_ids.size() != 0 && $urandom_range(3) != 0) ?
                            live_ids[$urandom_range(live_ids.size() - 1)] : $urandom);
            end else if (pick < 75)
                rq = mk_req(OP_CANCEL_CLT, $urandom, 20'($urandom), pick_nonce(), $urandom);
            else
                rq = mk_req(OP_POLL, clock_now, 20'($urandom), {$urandom, $urandom}, $urandom);
            send_op(rq);
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
